[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the blob centroid RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[hw/rtl/sbsc_pkg.sv]
// ----------------------------------------------------------------------------
// sbsc_pkg
// Types and constants shared by the blob span centroid modules.
// ----------------------------------------------------------------------------
package sbsc_pkg;

  localparam int PIX_W     = 8;   // pixel and configuration width
  localparam int POS_W     = 8;   // row and column position width
  localparam int SUM_W     = 24;  // coordinate sum width
  localparam int CNT_W     = 16;  // marked pixel count width
  localparam int CFG_IDX_W = 3;
  localparam int MAX_WIDTH = 256; // columns with span tracking
  localparam int COL_AW    = $clog2(MAX_WIDTH);
  localparam int STEP_W    = $clog2(SUM_W);

  // register reset values
  localparam logic [PIX_W-1:0] TARGET_RST = 8'd255;
  localparam logic [PIX_W-1:0] WIDTH_RST  = 8'd255;
  localparam logic [PIX_W-1:0] HEIGHT_RST = 8'd255;
  localparam logic [PIX_W-1:0] MAXSIDE_RST = 8'd255;
  localparam logic [PIX_W-1:0] TOL_RST    = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SHADE = 3'd0,
    CFG_IMAGE_WIDTH  = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_MAX_SIDE     = 3'd3,
    CFG_TOLERANCE    = 3'd4
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic accept;     // pixel transfer this cycle
    logic div_start;  // launch centroid division
    logic load_out;   // capture result, clear frame totals
  } sbsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;  // current pixel position is the last of the frame
    logic ok;         // span and count checks pass
    logic div_done;   // division finished
  } sbsc_sts_t;

endpackage

[hw/rtl/sbsc_if.sv]
// ----------------------------------------------------------------------------
// sbsc_pix_if / sbsc_res_if
// Valid/ready channels for pixels in and centroid results out.
// ----------------------------------------------------------------------------
interface sbsc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sbsc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] center_x;
  logic [7:0] center_y;
  logic       found;

  modport source (output valid, output center_x, output center_y, output found,
                  input ready);
  modport sink   (input valid, input center_x, input center_y, input found,
                  output ready);
endinterface

[hw/rtl/shade_blob_span_centroid_core.sv]
// ----------------------------------------------------------------------------
// shade_blob_span_centroid_core
// Single-shade blob centroid over a raster-order grayscale stream.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock in raster order; a pixel equal to the target
// shade is marked. At the last pixel of a frame the block stops taking pixels,
// runs the span checks and, if they pass, a bit-serial division of the x and
// y sums by the marked count. The result sits in an output register, so the
// next frame streams in while it waits to be taken; a frame end with the
// previous result still untaken holds off until it is. Configuration is to be
// written through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle,
// which the block itself does not enforce; registers are target shade, image
// width, image height, maximum side and span tolerance, in that index order.
// ----------------------------------------------------------------------------
module shade_blob_span_centroid_core import sbsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PIX_W-1:0]     cfg_data_i,
  sbsc_pix_if.sink             pix_i,
  sbsc_res_if.source           res_o
);

  sbsc_cmd_t cmd;
  sbsc_sts_t sts;

  sbsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sbsc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pixel_i    (pix_i.pixel),
    .center_x_o (res_o.center_x),
    .center_y_o (res_o.center_y),
    .found_o    (res_o.found)
  );

endmodule

[hw/rtl/sbsc_ctrl.sv]
// ----------------------------------------------------------------------------
// sbsc_ctrl
// Frame sequencer: streams pixels, then runs the end-of-frame check,
// division and result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbsc_ctrl import sbsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  sbsc_sts_t sts_i,
  output sbsc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_RUN,    // streaming pixels
    ST_FLUSH,  // last column update in flight
    ST_CHECK,  // span checks settle
    ST_DIV,    // centroid division
    ST_EMIT    // hand result to output register
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // commands
  assign in_ready_o       = (state_q == ST_RUN);
  assign cmd_o.accept     = in_valid_i && in_ready_o;
  assign cmd_o.div_start  = (state_q == ST_CHECK) && sts_i.ok;
  assign cmd_o.load_out   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o      = out_valid_q;

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_RUN: begin
          if (cmd_o.accept && sts_i.frame_end) state_q <= ST_FLUSH;
        end
        ST_FLUSH: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          state_q <= sts_i.ok ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (sts_i.div_done) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (cmd_o.load_out) state_q <= ST_RUN;
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  `ASSERT_PROP(a_frame_end_stalls, clk_i, rst_ni, cmd_o.accept && sts_i.frame_end |=> !in_ready_o, "input not stalled after frame end")
  `ASSERT_PROP(a_load_resumes, clk_i, rst_ni, cmd_o.load_out |=> out_valid_o && in_ready_o, "result load did not resume streaming")
  `ASSERT_PROP(a_done_in_div, clk_i, rst_ni, sts_i.div_done |-> state_q == ST_DIV, "division finished outside divide phase")

endmodule

[hw/rtl/sbsc_div.sv]
// ----------------------------------------------------------------------------
// sbsc_div
// Restoring divider, one quotient bit per cycle, two dividends sharing
// one divisor (x and y sums over the marked pixel count).
// ----------------------------------------------------------------------------
module sbsc_div import sbsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] num_x_i,
  input  logic [SUM_W-1:0] num_y_i,
  input  logic [CNT_W-1:0] den_i,
  output logic             done_o,
  output logic [POS_W-1:0] quo_x_o,
  output logic [POS_W-1:0] quo_y_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  nq_x_q, nq_y_q;   // dividend bits out, quotient bits in
  logic [CNT_W-1:0]  rem_x_q, rem_y_q;
  logic [CNT_W-1:0]  den_q;

  logic [CNT_W:0]    sh_x, sh_y;
  logic              ge_x, ge_y;
  logic [CNT_W-1:0]  rem_x_d, rem_y_d;

  // one trial subtraction per lane
  always_comb begin
    sh_x    = {rem_x_q, nq_x_q[SUM_W-1]};
    sh_y    = {rem_y_q, nq_y_q[SUM_W-1]};
    ge_x    = sh_x >= {1'b0, den_q};
    ge_y    = sh_y >= {1'b0, den_q};
    rem_x_d = ge_x ? CNT_W'(sh_x - {1'b0, den_q}) : sh_x[CNT_W-1:0];
    rem_y_d = ge_y ? CNT_W'(sh_y - {1'b0, den_q}) : sh_y[CNT_W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_x_q  <= num_x_i;
      nq_y_q  <= num_y_i;
      rem_x_q <= '0;
      rem_y_q <= '0;
      den_q   <= den_i;
    end else if (busy_q) begin
      nq_x_q  <= {nq_x_q[SUM_W-2:0], ge_x};
      nq_y_q  <= {nq_y_q[SUM_W-2:0], ge_y};
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
    end
  end

  assign done_o  = done_q;
  assign quo_x_o = nq_x_q[POS_W-1:0];
  assign quo_y_o = nq_y_q[POS_W-1:0];

endmodule

[hw/rtl/sbsc_datapath.sv]
// ----------------------------------------------------------------------------
// sbsc_datapath
// Configuration registers, pixel position counters, row and column span
// tracking, centroid sums, divider and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbsc_datapath import sbsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbsc_cmd_t            cmd_i,
  output sbsc_sts_t            sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PIX_W-1:0]     cfg_data_i,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic [POS_W-1:0]     center_x_o,
  output logic [POS_W-1:0]     center_y_o,
  output logic                 found_o
);

  // configuration
  logic [PIX_W-1:0] target_q, width_q, height_q, max_side_q, tol_q;

  // frame state
  logic [POS_W-1:0] col_pos_q, row_pos_q;
  logic [POS_W-1:0] row_first_q;
  logic             row_hit_q;
  logic [POS_W-1:0] row_span_q, col_span_q;
  logic [MAX_WIDTH-1:0] col_hit_q;
  logic [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [CNT_W-1:0] hit_cnt_q;

  // first marked row per column, and its pipelined compare
  logic [POS_W-1:0] col_first_mem [MAX_WIDTH];
  logic [POS_W-1:0] col_rd_q;
  logic [POS_W-1:0] s2_row_q;
  logic             s2_valid_q;

  // output register
  logic [POS_W-1:0] center_x_q, center_y_q;
  logic             found_q;

  logic [POS_W-1:0] w_last, h_last;
  logic             row_end, frame_end, match, col_ok, col_seen;
  logic [COL_AW-1:0] col_addr;
  logic [POS_W-1:0] row_diff, col_diff, span_diff;
  logic             mem_we, s2_load, ok;
  logic             div_done;
  logic [POS_W-1:0] quo_x, quo_y;

  // position decode; zero sizes act as one
  always_comb begin
    w_last    = (width_q == '0) ? '0 : width_q - 1'b1;
    h_last    = (height_q == '0) ? '0 : height_q - 1'b1;
    row_end   = col_pos_q >= w_last;
    frame_end = row_end && (row_pos_q >= h_last);
    match     = pixel_i == target_q;
    col_ok    = {1'b0, col_pos_q} < (POS_W+1)'(MAX_WIDTH);
    col_addr  = col_pos_q[COL_AW-1:0];
    col_seen  = col_hit_q[col_addr];
    row_diff  = col_pos_q - row_first_q;
    col_diff  = s2_row_q - col_rd_q;
    mem_we    = cmd_i.accept && match && col_ok && !col_seen;
    s2_load   = cmd_i.accept && match && col_ok && col_seen;
  end

  // end-of-frame checks
  always_comb begin
    span_diff = (row_span_q >= col_span_q) ? row_span_q - col_span_q
                                           : col_span_q - row_span_q;
    ok = (hit_cnt_q != '0) && (row_span_q <= max_side_q) &&
         (col_span_q <= max_side_q) && (span_diff <= tol_q);
  end

  assign sts_o.frame_end = frame_end;
  assign sts_o.ok        = ok;
  assign sts_o.div_done  = div_done;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_RST;
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      max_side_q <= MAXSIDE_RST;
      tol_q      <= TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_SHADE: target_q   <= cfg_data_i;
        CFG_IMAGE_WIDTH:  width_q    <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q   <= cfg_data_i;
        CFG_MAX_SIDE:     max_side_q <= cfg_data_i;
        CFG_TOLERANCE:    tol_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pixel stage: positions, row spans, column hits, sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      row_first_q <= '0;
      row_hit_q   <= 1'b0;
      row_span_q  <= '0;
      col_span_q  <= '0;
      col_hit_q   <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      hit_cnt_q   <= '0;
      s2_valid_q  <= 1'b0;
    end else begin
      s2_valid_q <= s2_load;
      // column span compare, in the cycle after the pixel
      if (s2_valid_q && (s2_row_q >= col_rd_q) && (col_diff > col_span_q)) begin
        col_span_q <= col_diff;
      end
      if (cmd_i.accept) begin
        if (match) begin
          if (!row_hit_q) begin
            row_hit_q   <= 1'b1;
            row_first_q <= col_pos_q;
          end else if ((col_pos_q >= row_first_q) && (row_diff > row_span_q)) begin
            row_span_q <= row_diff;
          end
          if (mem_we) col_hit_q[col_addr] <= 1'b1;
          sum_x_q   <= sum_x_q + SUM_W'(col_pos_q);
          sum_y_q   <= sum_y_q + SUM_W'(row_pos_q);
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end
        if (!row_end) begin
          col_pos_q <= col_pos_q + 1'b1;
        end else begin
          col_pos_q   <= '0;
          row_hit_q   <= 1'b0;
          row_first_q <= '0;
          if (!frame_end) begin
            row_pos_q <= row_pos_q + 1'b1;
          end else begin
            row_pos_q <= '0;
            col_hit_q <= '0;
          end
        end
      end
      // result taken into output register: clear frame totals
      if (cmd_i.load_out) begin
        row_span_q <= '0;
        col_span_q <= '0;
        sum_x_q    <= '0;
        sum_y_q    <= '0;
        hit_cnt_q  <= '0;
      end
    end
  end

  // first-row memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) col_first_mem[col_addr] <= row_pos_q;
    col_rd_q <= col_first_mem[col_addr];
    if (s2_load) s2_row_q <= row_pos_q;
  end

  // centroid division
  sbsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_x_i (sum_x_q),
    .num_y_i (sum_y_q),
    .den_i   (hit_cnt_q),
    .done_o  (div_done),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      center_x_q <= ok ? quo_x : '0;
      center_y_q <= ok ? quo_y : '0;
      found_q    <= ok;
    end
  end

  assign center_x_o = center_x_q;
  assign center_y_o = center_y_q;
  assign found_o    = found_q;

  `ASSERT_PROP(a_s2_follows_accept, clk_i, rst_ni, s2_valid_q |-> $past(cmd_i.accept), "column compare without a pixel")
  `ASSERT_PROP(a_empty_sums_zero, clk_i, rst_ni, hit_cnt_q == '0 |-> sum_x_q == '0 && sum_y_q == '0, "sums nonzero with no marked pixel")
  `ASSERT_PROP(a_done_checks_ok, clk_i, rst_ni, div_done |-> ok, "division ran on a failing frame")

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for shade_blob_span_centroid_core. Streams frames of
// pixels through the valid/ready input, predicts each frame's centroid
// result in a cycle-free model of the span and sum logic, and compares every
// transfer on the result channel against the oldest pending prediction.
// Directed frames cover reset values, zero sizes, a mid-frame size change
// and span limits; random frames with blobs, noise and broken frames follow,
// with random idling on both sides and a long result stall.
// ----------------------------------------------------------------------------
module tb_top import sbsc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned SETTLE_CYC   = 40;        // frame-end divide plus output reg
  localparam int unsigned TAIL_CYC     = 64;
  localparam int unsigned STALL_CYC    = 300;
  localparam longint      LIMIT_NS     = 4_000_000;

  typedef struct packed {
    logic [PIX_W-1:0] center_x;
    logic [PIX_W-1:0] center_y;
    logic             found;
  } centroid_t;

  typedef enum {FRAME_BLOB, FRAME_NOISE, FRAME_EMPTY, FRAME_FULL} frame_kind_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PIX_W-1:0]     cfg_data_i;

  sbsc_pix_if pix_if ();
  sbsc_res_if res_if ();

  shade_blob_span_centroid_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bookkeeping
  centroid_t   expected_centroids[$];
  int unsigned mismatches;
  int unsigned pixels_seen;
  int unsigned results_seen;
  int unsigned blobs_found;
  int unsigned config_phases;
  bit          sender_calm;
  bit          receiver_calm;
  int unsigned stall_left;

  // ---------------------------------------------------------------------------
  // Centroid predictor: configuration and frame state
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] cfg_shade, cfg_width, cfg_height, cfg_max_side, cfg_tol;

  logic [POS_W-1:0] blob_col, blob_row, blob_row_first;
  bit               blob_row_hit;
  logic [POS_W-1:0] blob_row_span, blob_col_span;
  logic [POS_W-1:0] blob_col_first[MAX_WIDTH];
  bit               blob_col_hit[MAX_WIDTH];
  logic [SUM_W-1:0] blob_sum_x, blob_sum_y;
  logic [CNT_W-1:0] blob_count;

  function automatic void clear_blob_frame();
    blob_col       = '0;
    blob_row       = '0;
    blob_row_first = '0;
    blob_row_hit   = 1'b0;
    blob_row_span  = '0;
    blob_col_span  = '0;
    blob_sum_x     = '0;
    blob_sum_y     = '0;
    blob_count     = '0;
    for (int i = 0; i < MAX_WIDTH; i++) blob_col_hit[i] = 1'b0;
  endfunction

  // Advance by one pixel; returns 1 with the frame result on the last pixel.
  function automatic bit centroid_step(input logic [PIX_W-1:0] px, output centroid_t res);
    logic [POS_W-1:0] col_last, row_last, span_gap;
    logic [SUM_W-1:0] quot_x, quot_y;
    bit               row_end, frame_end, ok;
    res      = '0;
    col_last = (cfg_width == '0) ? '0 : cfg_width - 8'd1;   // zero size acts as one
    row_last = (cfg_height == '0) ? '0 : cfg_height - 8'd1;

    if (px == cfg_shade) begin
      if (!blob_row_hit) begin
        blob_row_hit   = 1'b1;
        blob_row_first = blob_col;
      end else if (blob_col >= blob_row_first && blob_col - blob_row_first > blob_row_span) begin
        blob_row_span = blob_col - blob_row_first;
      end
      if (!blob_col_hit[blob_col]) begin
        blob_col_hit[blob_col]   = 1'b1;
        blob_col_first[blob_col] = blob_row;
      end else if (blob_row >= blob_col_first[blob_col] &&
                   blob_row - blob_col_first[blob_col] > blob_col_span) begin
        blob_col_span = blob_row - blob_col_first[blob_col];
      end
      blob_sum_x = blob_sum_x + SUM_W'(blob_col);
      blob_sum_y = blob_sum_y + SUM_W'(blob_row);
      blob_count = blob_count + 1'b1;
    end

    // position compares use >= so a size shrunk mid-frame ends the row/frame
    row_end   = blob_col >= col_last;
    frame_end = row_end && (blob_row >= row_last);
    if (!row_end) begin
      blob_col = blob_col + 1'b1;
      return 1'b0;
    end
    blob_col       = '0;
    blob_row_hit   = 1'b0;
    blob_row_first = '0;
    if (!frame_end) begin
      blob_row = blob_row + 1'b1;
      return 1'b0;
    end

    span_gap = (blob_row_span >= blob_col_span) ? blob_row_span - blob_col_span
                                                : blob_col_span - blob_row_span;
    ok = (blob_count != '0) && (blob_row_span <= cfg_max_side) &&
         (blob_col_span <= cfg_max_side) && (span_gap <= cfg_tol);
    if (ok) begin
      quot_x       = blob_sum_x / SUM_W'(blob_count);
      quot_y       = blob_sum_y / SUM_W'(blob_count);
      res.center_x = quot_x[PIX_W-1:0];
      res.center_y = quot_y[PIX_W-1:0];
      res.found    = 1'b1;
    end
    clear_blob_frame();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check result transfers, then predict from pixel transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    centroid_t got, want, next_res;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.center_x, res_if.center_y, res_if.found};
      results_seen++;
      if (expected_centroids.size() == 0) begin
        flag_mismatch($sformatf("result %0d (x=%0d y=%0d found=%0b) with none pending",
                                results_seen, got.center_x, got.center_y, got.found));
      end else begin
        want = expected_centroids.pop_front();
        if (want.found) blobs_found++;
        if (got !== want)
          flag_mismatch($sformatf("result %0d got x=%0d y=%0d f=%0b, want x=%0d y=%0d f=%0b",
                                  results_seen, got.center_x, got.center_y, got.found,
                                  want.center_x, want.center_y, want.found));
      end
    end
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      pixels_seen++;
      if (centroid_step(pix_if.pixel, next_res)) expected_centroids.push_back(next_res);
    end
  end

  // Result side: random back-pressure, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= receiver_calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One pixel transfer; called and returns at a rising edge.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // Drop valid, wait for all pending results, then let the block go quiet.
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_centroids.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [PIX_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TARGET_SHADE: cfg_shade    = val;
      CFG_IMAGE_WIDTH:  cfg_width    = val;
      CFG_IMAGE_HEIGHT: cfg_height   = val;
      CFG_MAX_SIDE:     cfg_max_side = val;
      CFG_TOLERANCE:    cfg_tol      = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [PIX_W-1:0] shade, input logic [PIX_W-1:0] width,
                              input logic [PIX_W-1:0] height, input logic [PIX_W-1:0] max_side,
                              input logic [PIX_W-1:0] tol);
    wait_idle();
    write_reg(CFG_TARGET_SHADE, shade);
    write_reg(CFG_IMAGE_WIDTH, width);
    write_reg(CFG_IMAGE_HEIGHT, height);
    write_reg(CFG_MAX_SIDE, max_side);
    write_reg(CFG_TOLERANCE, tol);
    config_phases++;
  endtask

  function automatic logic [PIX_W-1:0] non_target();
    logic [PIX_W-1:0] v;
    v = PIX_W'($urandom_range(0, 255));
    if (v == cfg_shade) v = ~v;
    return v;
  endfunction

  // sometimes zero, sometimes the given top, else a value in 0..hi
  function automatic logic [PIX_W-1:0] pick_reg(input int unsigned hi, input logic [PIX_W-1:0] top);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return top;
    return PIX_W'($urandom_range(0, hi));
  endfunction

  // One frame at the current size; stop_after > 0 cuts it short.
  task automatic send_frame(input frame_kind_e kind, input int unsigned stop_after);
    int unsigned      w, h, x0, x1, y0, y1, sent;
    logic [PIX_W-1:0] px;
    bit               in_blob;
    w  = (cfg_width == '0) ? 1 : cfg_width;
    h  = (cfg_height == '0) ? 1 : cfg_height;
    x0 = $urandom_range(0, w - 1);
    x1 = $urandom_range(x0, w - 1);
    y0 = $urandom_range(0, h - 1);
    y1 = $urandom_range(y0, h - 1);
    sent = 0;
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if (stop_after != 0 && sent == stop_after) return;
        in_blob = (c >= x0) && (c <= x1) && (r >= y0) && (r <= y1);
        case (kind)
          FRAME_BLOB:  px = ($urandom_range(0, 99) < (in_blob ? 85 : 3)) ? cfg_shade
                                                                          : non_target();
          FRAME_NOISE: px = ($urandom_range(0, 99) < 25) ? cfg_shade
                                                         : PIX_W'($urandom_range(0, 255));
          FRAME_EMPTY: px = non_target();
          default:     px = cfg_shade;
        endcase
        send_pixel(px);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // shade, max side and tolerance keep their reset values
  task automatic test_reset_values();
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 8'd3);
    write_reg(CFG_IMAGE_HEIGHT, 8'd2);
    send_pixel(8'd255);
    send_pixel(8'd7);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
  endtask

  // zero width and height act as one: each pixel is a frame; second is empty
  task automatic test_zero_size();
    apply_config(8'd0, 8'd0, 8'd0, 8'd255, 8'd8);
    send_pixel(8'd0);
    send_pixel(8'd255);
  endtask

  // width shrinks below the current column: the row ends on the next pixel
  task automatic test_size_change_midframe();
    apply_config(8'hA5, 8'd4, 8'd2, 8'd255, 8'd255);
    send_pixel(8'hA5);
    send_pixel(8'h5A);
    send_pixel(8'hA5);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 8'd2);
    send_pixel(8'hA5);
    send_pixel(8'hA5);
    send_pixel(8'hA5);
  endtask

  // spans of 2 against a max side of 1: not found
  task automatic test_span_limits();
    apply_config(8'h3C, 8'd3, 8'd3, 8'd1, 8'd0);
    send_frame(FRAME_FULL, 0);
  endtask

  // full-length row and column against max side and tolerance extremes
  task automatic test_extreme_sizes();
    apply_config(PIX_W'($urandom_range(0, 255)), 8'd255, 8'd1, 8'd254, 8'd255);
    send_frame(FRAME_FULL, 0);
    apply_config(PIX_W'($urandom_range(0, 255)), 8'd1, 8'd255, 8'd253, 8'd255);
    send_frame(FRAME_FULL, 0);
  endtask

  // one-pixel frames while results are held off: the block must stall pixels
  task automatic test_result_backpressure();
    apply_config(PIX_W'($urandom_range(0, 255)), 8'd1, 8'd1, 8'd255, 8'd8);
    sender_calm = 1'b1;
    stall_left  = STALL_CYC;
    repeat (30) send_pixel($urandom_range(0, 1) ? cfg_shade : non_target());
    sender_calm = 1'b0;
  endtask

  // back-to-back transfers on both sides
  task automatic test_streaming();
    apply_config(PIX_W'($urandom_range(0, 255)), 8'd16, 8'd8, pick_reg(12, 8'd255),
                 pick_reg(6, 8'd255));
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    repeat (2) send_frame(FRAME_BLOB, 0);
    wait_idle();
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  // random configs and frame mixes; some frames are cut short so the next
  // config change lands mid-frame
  task automatic test_random_frames();
    int unsigned px_base, res_base, roll, area;
    frame_kind_e kind;
    px_base  = pixels_seen;
    res_base = results_seen;
    while (pixels_seen - px_base < 600 || results_seen - res_base < 48) begin
      apply_config(pick_reg(255, 8'd255), pick_reg(6, 8'd1), pick_reg(6, 8'd1),
                   pick_reg(7, 8'd255), pick_reg(4, 8'd255));
      repeat ($urandom_range(1, 4)) begin
        roll = $urandom_range(0, 99);
        kind = (roll < 70) ? FRAME_BLOB : (roll < 85) ? FRAME_NOISE :
               (roll < 93) ? FRAME_EMPTY : FRAME_FULL;
        send_frame(kind, 0);
      end
      area = ((cfg_width == '0) ? 1 : cfg_width) * ((cfg_height == '0) ? 1 : cfg_height);
      if (area > 1 && $urandom_range(0, 99) < 10)
        send_frame(FRAME_NOISE, $urandom_range(1, area - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    pix_if.valid  = 1'b0;
    pix_if.pixel  = '0;
    res_if.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_TARGET_SHADE;
    cfg_data_i    = '0;
    mismatches    = 0;
    pixels_seen   = 0;
    results_seen  = 0;
    blobs_found   = 0;
    config_phases = 0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    stall_left    = 0;
    cfg_shade     = TARGET_RST;
    cfg_width     = WIDTH_RST;
    cfg_height    = HEIGHT_RST;
    cfg_max_side  = MAXSIDE_RST;
    cfg_tol       = TOL_RST;
    for (int i = 0; i < MAX_WIDTH; i++) blob_col_first[i] = '0;
    clear_blob_frame();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_zero_size();
    test_size_change_midframe();
    test_span_limits();
    test_extreme_sizes();
    test_result_backpressure();
    test_streaming();
    test_random_frames();

    wait_idle();
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("Covered %0d pixel transfers and %0d frame results, %0d with a blob found.",
             pixels_seen, results_seen, blobs_found);
    $display("Ran %0d register settings: zero and full sizes, a mid-frame resize, %s",
             config_phases, "a long result hold-off.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sbsc_pkg.sv
hw/rtl/sbsc_if.sv
hw/rtl/sbsc_ctrl.sv
hw/rtl/sbsc_div.sv
hw/rtl/sbsc_datapath.sv
hw/rtl/shade_blob_span_centroid_core.sv
bench/tb_top.sv
